/* rtl/core/rg32_pkg.sv */
// ----------------------------------------------------------------------------
// rg32_pkg
// Types, constants and the belt-and-mill round function of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rg32_pkg;

    localparam int MILL_WORDS   = 19;
    localparam int BELT_WORDS   = 40;
    localparam int ROW_STRIDE   = 13;
    localparam int BLANK_ROUNDS = 17;
    localparam int BLOCK_WORDS  = 3;

    // Default seed "1234" packed little-endian, and the pad byte
    localparam logic [31:0] DEFAULT_SEED_WORD = 32'h3433_3231;
    localparam logic [31:0] PAD_WORD          = 32'h0000_0001;

    // Operation codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ABSORB = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_DRAW   = 2'd3;

    typedef logic [BELT_WORDS-1:0][31:0] belt_t;
    typedef logic [MILL_WORDS-1:0][31:0] mill_t;

    typedef struct packed {
        belt_t belt;
        mill_t mill;
    } engine_t;

    // Rotate right by r bits
    function automatic logic [31:0] rg_rotr(logic [31:0] x, int r);
        logic [63:0] d;
        d = {x, x} >> r;
        return d[31:0];
    endfunction

    // Swap the bytes inside each 16-bit half
    function automatic logic [31:0] rg_half_swap(logic [31:0] w);
        return {w[23:16], w[31:24], w[7:0], w[15:8]};
    endfunction

    // XOR a seed word into belt row and mill word of the given slot
    function automatic engine_t rg_inject(engine_t e, logic [1:0] slot, logic [31:0] w);
        engine_t n;
        n = e;
        case (slot)
            2'd0:
            begin
                n.belt[0]  = e.belt[0] ^ w;
                n.mill[16] = e.mill[16] ^ w;
            end
            2'd1:
            begin
                n.belt[ROW_STRIDE] = e.belt[ROW_STRIDE] ^ w;
                n.mill[17]         = e.mill[17] ^ w;
            end
            default:
            begin
                n.belt[2*ROW_STRIDE] = e.belt[2*ROW_STRIDE] ^ w;
                n.mill[18]           = e.mill[18] ^ w;
            end
        endcase
        return n;
    endfunction

    // One full belt-and-mill round
    function automatic engine_t rg_round(engine_t e);
        engine_t     n;
        mill_t       t;
        logic [31:0] x;
        int          r;
        int          y;
        n = e;
        r = 0;
        // feed mill into belt rows
        for (int c = 0; c < 12; c++)
        begin
            n.belt[c + (c % 3) * ROW_STRIDE] = n.belt[c + (c % 3) * ROW_STRIDE]
                                               ^ e.mill[c + 1];
        end
        // gamma and pi steps
        for (int c = 0; c < MILL_WORDS; c++)
        begin
            y    = c * 7;
            x    = e.mill[y % MILL_WORDS]
                   ^ (e.mill[(y + 1) % MILL_WORDS] | ~e.mill[(y + 2) % MILL_WORDS]);
            r    = (r + c) & 31;
            t[c] = rg_rotr(x, r);
        end
        // rotate the belt
        for (int c = BELT_WORDS - 1; c > 0; c--)
        begin
            n.belt[c] = n.belt[c - 1];
        end
        // theta step
        for (int c = 0; c < MILL_WORDS; c++)
        begin
            n.mill[c] = t[c] ^ t[(c + 1) % MILL_WORDS] ^ t[(c + 4) % MILL_WORDS];
        end
        n.mill[0] = n.mill[0] ^ 32'd1;
        // belt to mill feedback
        for (int c = 0; c < 3; c++)
        begin
            n.belt[c * ROW_STRIDE]  = n.belt[c * ROW_STRIDE + ROW_STRIDE];
            n.mill[13 + c]          = n.mill[13 + c] ^ n.belt[c * ROW_STRIDE];
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/radiogatun32_stream_generator_top.sv */
// ----------------------------------------------------------------------------
// radiogatun32_stream_generator_top
// Start seed and absorb byte are registered when accepted, and a byte that
// completes a three-word block also runs a round. Finish seed runs the blank
// rounds. Draw: result registered directly when no round is due, after a
// round when one runs first, and after the blank rounds on an unseeded draw.
// Throughput is set by the single round unit: one round per cycle, one request
// at a time. Asynchronous reset clears belt, mill and all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module radiogatun32_stream_generator_top
    import rg32_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  seed_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_value,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_DRAW,
        S_EMIT
    } state_t;

    localparam int CNT_W = $clog2(BLANK_ROUNDS + 1);

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [CNT_W-1:0]   rcnt_reg, rcnt_next;
    engine_t            eng_reg, eng_next;
    engine_t            eng_round;
    logic               phase_reg, phase_next;
    logic               seeded_reg, seeded_next;
    logic [31:0]        pending_reg, pending_next;
    logic [1:0]         bcount_reg, bcount_next;
    logic [1:0]         slot_reg, slot_next;
    logic [31:0]        held_reg, held_next;
    logic               hsel_reg, hsel_next;
    logic               half_mode_reg, half_mode_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_value_reg, out_value_next;

    logic               can_emit;
    logic               accept;
    logic               decide;
    logic               emit;
    logic [31:0]        emit_word;
    logic [31:0]        swapped;
    logic [31:0]        absorbed;
    logic [31:0]        padded;

    assign eng_round = rg_round(eng_reg);
    assign can_emit  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !can_emit;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign absorbed  = pending_reg | ({24'd0, seed_byte} << {bcount_reg, 3'b000});
    assign padded    = pending_reg | (PAD_WORD << {bcount_reg, 3'b000});
    assign swapped   = rg_half_swap(emit_word);

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        rcnt_next      = rcnt_reg;
        eng_next       = eng_reg;
        phase_next     = phase_reg;
        seeded_next    = seeded_reg;
        pending_next   = pending_reg;
        bcount_next    = bcount_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        hsel_next      = hsel_reg;
        half_mode_next = half_mode_reg;
        out_value_next = out_value_reg;
        decide         = 1'b0;
        emit           = 1'b0;
        emit_word      = eng_reg.mill[1];

        // take configuration writes
        if (cfg_valid)
        begin
            half_mode_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_START:
                        begin
                            eng_next     = '0;
                            pending_next = '0;
                            bcount_next  = '0;
                            slot_next    = '0;
                            seeded_next  = 1'b0;
                        end
                        OP_ABSORB:
                        begin
                            if (seed_byte != 8'd0)
                            begin
                                if (bcount_reg == 2'd3)
                                begin
                                    eng_next     = rg_inject(eng_reg, slot_reg, absorbed);
                                    pending_next = '0;
                                    bcount_next  = '0;
                                    if (slot_reg == 2'(BLOCK_WORDS - 1))
                                    begin
                                        slot_next  = '0;
                                        rcnt_next  = CNT_W'(1);
                                        ret_next   = S_IDLE;
                                        state_next = S_ROUND;
                                    end
                                    else
                                    begin
                                        slot_next = slot_reg + 2'd1;
                                    end
                                end
                                else
                                begin
                                    pending_next = absorbed;
                                    bcount_next  = bcount_reg + 2'd1;
                                end
                            end
                        end
                        OP_FINISH:
                        begin
                            eng_next     = rg_inject(eng_reg, slot_reg, padded);
                            pending_next = '0;
                            bcount_next  = '0;
                            slot_next    = '0;
                            seeded_next  = 1'b1;
                            phase_next   = 1'b0;
                            hsel_next    = 1'b0;
                            held_next    = '0;
                            rcnt_next    = CNT_W'(BLANK_ROUNDS);
                            ret_next     = S_IDLE;
                            state_next   = S_ROUND;
                        end
                        default:
                        begin
                            if (!seeded_reg)
                            begin
                                // seed with "1234" and the pad word, then blank rounds
                                eng_next                   = '0;
                                eng_next.belt[0]           = DEFAULT_SEED_WORD;
                                eng_next.mill[16]          = DEFAULT_SEED_WORD;
                                eng_next.belt[ROW_STRIDE]  = PAD_WORD;
                                eng_next.mill[17]          = PAD_WORD;
                                pending_next               = '0;
                                bcount_next                = '0;
                                slot_next                  = '0;
                                seeded_next                = 1'b1;
                                phase_next                 = 1'b0;
                                rcnt_next                  = CNT_W'(BLANK_ROUNDS);
                                ret_next                   = S_DRAW;
                                state_next                 = S_ROUND;
                            end
                            else
                            begin
                                decide = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_ROUND:
            begin
                eng_next  = eng_round;
                rcnt_next = rcnt_reg - CNT_W'(1);
                if (rcnt_reg == CNT_W'(1))
                begin
                    state_next = ret_reg;
                end
            end
            S_DRAW:
            begin
                if (can_emit)
                begin
                    decide     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_word  = eng_reg.mill[1];
                    phase_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // draw on a seeded engine
        if (decide)
        begin
            if (half_mode_reg && hsel_reg)
            begin
                emit = 1'b1;
            end
            else if (phase_reg)
            begin
                emit       = 1'b1;
                emit_word  = eng_reg.mill[2];
                phase_next = 1'b0;
            end
            else
            begin
                rcnt_next  = CNT_W'(1);
                ret_next   = S_EMIT;
                state_next = S_ROUND;
            end
        end

        // format the drawn word
        if (emit)
        begin
            if (!half_mode_reg)
            begin
                out_value_next = emit_word;
            end
            else if (hsel_reg)
            begin
                held_next      = {16'd0, held_reg[31:16]};
                out_value_next = {16'd0, held_reg[31:16]};
                hsel_next      = 1'b0;
            end
            else
            begin
                held_next      = swapped;
                out_value_next = {16'd0, swapped[15:0]};
                hsel_next      = 1'b1;
            end
        end

        // hold or drop the result register
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            rcnt_reg      <= '0;
            eng_reg       <= '0;
            phase_reg     <= 1'b0;
            seeded_reg    <= 1'b0;
            pending_reg   <= '0;
            bcount_reg    <= '0;
            slot_reg      <= '0;
            held_reg      <= '0;
            hsel_reg      <= 1'b0;
            half_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            rcnt_reg      <= rcnt_next;
            eng_reg       <= eng_next;
            phase_reg     <= phase_next;
            seeded_reg    <= seeded_next;
            pending_reg   <= pending_next;
            bcount_reg    <= bcount_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            hsel_reg      <= hsel_next;
            half_mode_reg <= half_mode_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
        end
    end

    // Sequencer checks
    a_round_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (rcnt_reg != '0))
        else $error("round state with zero count");

    a_finish_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_FINISH) |=>
            (state_reg == S_ROUND && rcnt_reg == CNT_W'(BLANK_ROUNDS)))
        else $error("finish seed did not start the blank rounds");

    a_draw_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW || state_reg == S_EMIT) |-> seeded_reg)
        else $error("draw on an unseeded engine");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg != 2'd3)
        else $error("word slot out of range");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while sequencer busy");

endmodule

`default_nettype wire
